// ----- src/imh_pkg.sv -----
// Shared constants, codes and field widths of the indexed min-heap.
package imh_pkg;

   localparam int HEAP_DEPTH_DEF = 1024;
   localparam int NODE_IDS_DEF   = 1024;
   localparam int KEY_BITS_DEF   = 24;

   localparam int REQ_TYPE_W = 2;
   localparam int NODE_ID_W  = 10;
   localparam int NEW_KEY_W  = 24;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 11;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_POP    = 2'd1,
      REQ_CHANGE = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_ABSENT = 2'd3
   } status_code_type;

endpackage

// ----- src/imh_if.sv -----
// Request and response channel interfaces of the indexed min-heap.
interface imh_req_if;
   import imh_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [NODE_ID_W-1:0]  node_id;
   logic [NEW_KEY_W-1:0]  new_key;
   modport source (output valid, req_type, node_id, new_key, input ready);
   modport sink   (input valid, req_type, node_id, new_key, output ready);
endinterface

interface imh_rsp_if;
   import imh_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [NODE_ID_W-1:0] out_node;
   logic [NEW_KEY_W-1:0] out_key;
   logic [COUNT_W-1:0]   entry_count;
   modport source (output valid, status, out_node, out_key, entry_count, input ready);
   modport sink   (input valid, status, out_node, out_key, entry_count, output ready);
endinterface

// ----- src/imh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module imh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- src/indexed_min_heap_core.sv -----
// Indexed binary min-heap with per-node position table and sequential sift engine.
//
// Usage: requests arrive on req (insert, pop minimum, change key) and each
// produces exactly one response on rsp with a status, the popped node and
// key (zero unless a pop succeeds) and the entry count after the request.
// Both channels transfer when valid and ready are high at a clock edge.
//
// One request is worked at a time: req.ready is high only while the engine
// is idle. The heap sits in one RAM of {node, key} words and the position
// table with its present bit in a second RAM; each sift level is a read of
// the heap RAM port followed by a compare and write. The single heap RAM
// read port sets the pace of each sift.
//
// After reset the engine sweeps the position table, one entry per cycle,
// clearing every present bit, with req.ready low until the sweep ends.
// The response sits in an output register; a new request is taken while
// it waits, and the engine holds its next response until rsp.ready.
module indexed_min_heap_core #(
   parameter int HEAP_DEPTH = imh_pkg::HEAP_DEPTH_DEF,
   parameter int NODE_IDS   = imh_pkg::NODE_IDS_DEF,
   parameter int KEY_BITS   = imh_pkg::KEY_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   imh_req_if.sink     req,
   imh_rsp_if.source   rsp
);
   import imh_pkg::*;

   localparam int SW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW  = $clog2(HEAP_DEPTH + 1);
   localparam int NW  = (NODE_IDS > 1) ? $clog2(NODE_IDS) : 1;
   localparam int XW  = ((NW > NODE_ID_W) ? NW : NODE_ID_W) + 1;
   localparam int EW  = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int LW  = SW + 2;
   localparam int HW  = NW + KEY_BITS;
   localparam int PW  = SW + 1;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_CHK, S_POP0, S_POP1, S_UP, S_UP_CMP,
      S_DOWN, S_DOWN_L, S_DOWN_R, S_PLACE, S_FIN
   } state_type;

   state_type             state_ff;
   logic [NW-1:0]         clr_ff;
   logic [CW-1:0]         fill_ff;
   logic [SW-1:0]         cur_ff;
   logic [KEY_BITS-1:0]   mov_key_ff;
   logic [NW-1:0]         mov_node_ff;
   logic [XW-1:0]         node_ff;
   req_code_type          op_ff;
   logic                  moved_ff;
   logic [KEY_BITS-1:0]   lkey_ff;
   logic [NW-1:0]         lnode_ff;
   status_code_type       status_ff;
   logic [NW-1:0]         onode_ff;
   logic [KEY_BITS-1:0]   okey_ff;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [NODE_ID_W-1:0]  rsp_node_ff;
   logic [NEW_KEY_W-1:0]  rsp_key_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic              h_we;
   logic [SW-1:0]     h_waddr, h_raddr;
   logic [HW-1:0]     h_wdata, h_rdata;
   logic              p_we;
   logic [NW-1:0]     p_waddr, p_raddr;
   logic [PW-1:0]     p_wdata, p_rdata;

   logic [XW-1:0]       req_node_x;
   logic [KEY_BITS-1:0] req_key;
   logic [LW-1:0]       left_w, right_w, fill_w;
   logic [SW-1:0]       parent;
   logic                has_left, has_right;
   logic [KEY_BITS-1:0] rd_key, pk_key;
   logic [NW-1:0]       rd_node, pk_node;
   logic [SW-1:0]       pk_slot;
   logic                pk_go, pk_move, up_move;
   logic                id_valid, present;
   logic [SW-1:0]       pos_slot;

   imh_ram #(.WIDTH(HW), .DEPTH(HEAP_DEPTH)) u_heap_ram (
      .clock(clock), .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
      .rd_addr(h_raddr), .rd_data(h_rdata)
   );

   imh_ram #(.WIDTH(PW), .DEPTH(NODE_IDS)) u_pos_ram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
      .rd_addr(p_raddr), .rd_data(p_rdata)
   );

   always_comb begin
      req_node_x = XW'(req.node_id);
      req_key    = KEY_BITS'(32'(req.new_key));
      left_w     = {1'b0, cur_ff, 1'b1};
      right_w    = left_w + 1'b1;
      fill_w     = LW'(fill_ff);
      parent     = SW'((cur_ff - 1'b1) >> 1);
      has_left   = left_w < fill_w;
      has_right  = right_w < fill_w;
      rd_key     = h_rdata[KEY_BITS-1:0];
      rd_node    = h_rdata[HW-1:KEY_BITS];
      id_valid   = node_ff < XW'(NODE_IDS);
      present    = p_rdata[PW-1];
      pos_slot   = p_rdata[SW-1:0];
      up_move    = mov_key_ff < rd_key;
      // on equal children take the right one
      if (state_ff == S_DOWN_R && !(lkey_ff < rd_key)) begin
         pk_key  = rd_key;
         pk_node = rd_node;
         pk_slot = right_w[SW-1:0];
      end else begin
         pk_key  = (state_ff == S_DOWN_R) ? lkey_ff : rd_key;
         pk_node = (state_ff == S_DOWN_R) ? lnode_ff : rd_node;
         pk_slot = left_w[SW-1:0];
      end
      pk_go   = (state_ff == S_DOWN_R) || (state_ff == S_DOWN_L && !has_right);
      pk_move = pk_go && (pk_key < mov_key_ff);
   end

   // RAM read addresses
   always_comb begin
      h_raddr = '0;
      p_raddr = req_node_x[NW-1:0];
      unique case (state_ff)
         S_POP0:  h_raddr = SW'(fill_ff - 1'b1);
         S_UP:    h_raddr = parent;
         S_DOWN:  h_raddr = left_w[SW-1:0];
         S_DOWN_L: h_raddr = right_w[SW-1:0];
         S_CLR, S_IDLE, S_CHK, S_POP1, S_UP_CMP, S_DOWN_R, S_PLACE, S_FIN: h_raddr = '0;
      endcase
   end

   // RAM writes
   always_comb begin
      h_we    = 1'b0;
      h_waddr = cur_ff;
      h_wdata = {mov_node_ff, mov_key_ff};
      p_we    = 1'b0;
      p_waddr = mov_node_ff;
      p_wdata = {1'b1, cur_ff};
      priority if (state_ff == S_CLR) begin
         p_we    = 1'b1;
         p_waddr = clr_ff;
         p_wdata = '0;
      end else if (state_ff == S_POP0 && fill_ff != '0) begin
         p_we    = 1'b1;
         p_waddr = rd_node;
         p_wdata = '0;
      end else if (state_ff == S_UP_CMP && up_move) begin
         h_we    = 1'b1;
         h_wdata = h_rdata;
         p_we    = 1'b1;
         p_waddr = rd_node;
      end else if (pk_move) begin
         h_we    = 1'b1;
         h_wdata = {pk_node, pk_key};
         p_we    = 1'b1;
         p_waddr = pk_node;
      end else if (state_ff == S_PLACE) begin
         h_we = 1'b1;
         p_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the response after its transfer unless a new one loads now
         if (rsp_valid_ff && rsp.ready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == NW'(NODE_IDS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req.valid) begin
                  op_ff      <= req_code_type'(req.req_type);
                  node_ff    <= req_node_x;
                  mov_node_ff <= req_node_x[NW-1:0];
                  mov_key_ff <= req_key;
                  moved_ff   <= 1'b0;
                  status_ff  <= ST_OK;
                  onode_ff   <= '0;
                  okey_ff    <= '0;
                  unique case (req_code_type'(req.req_type))
                     REQ_INSERT, REQ_CHANGE: state_ff <= S_CHK;
                     REQ_POP:                state_ff <= S_POP0;
                     REQ_NONE:               state_ff <= S_FIN;
                  endcase
               end
            end
            S_CHK: begin
               if (op_ff == REQ_INSERT) begin
                  priority if (!id_valid || present) begin
                     status_ff <= ST_ABSENT;
                     state_ff  <= S_FIN;
                  end else if (fill_ff >= CW'(HEAP_DEPTH)) begin
                     status_ff <= ST_FULL;
                     state_ff  <= S_FIN;
                  end else begin
                     cur_ff   <= SW'(fill_ff);
                     fill_ff  <= fill_ff + 1'b1;
                     state_ff <= S_UP;
                  end
               end else begin
                  if (!id_valid || !present || CW'(pos_slot) >= fill_ff) begin
                     status_ff <= ST_ABSENT;
                     state_ff  <= S_FIN;
                  end else begin
                     cur_ff   <= pos_slot;
                     state_ff <= S_UP;
                  end
               end
            end
            S_POP0: begin
               if (fill_ff == '0) begin
                  status_ff <= ST_EMPTY;
                  state_ff  <= S_FIN;
               end else begin
                  onode_ff <= rd_node;
                  okey_ff  <= rd_key;
                  fill_ff  <= fill_ff - 1'b1;
                  state_ff <= (fill_ff == CW'(1)) ? S_FIN : S_POP1;
               end
            end
            S_POP1: begin
               mov_node_ff <= rd_node;
               mov_key_ff  <= rd_key;
               cur_ff      <= '0;
               state_ff    <= S_DOWN;
            end
            S_UP: begin
               if (cur_ff == '0) begin
                  state_ff <= (op_ff == REQ_CHANGE && !moved_ff) ? S_DOWN : S_PLACE;
               end else begin
                  state_ff <= S_UP_CMP;
               end
            end
            S_UP_CMP: begin
               if (up_move) begin
                  cur_ff   <= parent;
                  moved_ff <= 1'b1;
                  state_ff <= S_UP;
               end else begin
                  state_ff <= (op_ff == REQ_CHANGE && !moved_ff) ? S_DOWN : S_PLACE;
               end
            end
            S_DOWN: begin
               state_ff <= has_left ? S_DOWN_L : S_PLACE;
            end
            S_DOWN_L: begin
               lkey_ff  <= rd_key;
               lnode_ff <= rd_node;
               if (has_right) begin
                  state_ff <= S_DOWN_R;
               end else if (pk_move) begin
                  cur_ff   <= pk_slot;
                  state_ff <= S_DOWN;
               end else begin
                  state_ff <= S_PLACE;
               end
            end
            S_DOWN_R: begin
               if (pk_move) begin
                  cur_ff   <= pk_slot;
                  state_ff <= S_DOWN;
               end else begin
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: begin
               state_ff <= S_FIN;
            end
            S_FIN: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_node_ff   <= NODE_ID_W'(XW'(onode_ff));
                  rsp_key_ff    <= NEW_KEY_W'(32'(okey_ff));
                  rsp_count_ff  <= COUNT_W'(EW'(fill_ff));
                  state_ff      <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.out_node    = rsp_node_ff;
   assign rsp.out_key     = rsp_key_ff;
   assign rsp.entry_count = rsp_count_ff;

endmodule

// ----- src/imh_checker.sv -----
// Port-level checks of the indexed min-heap, bound to the top level.
module imh_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [imh_pkg::STATUS_W-1:0]   rsp_status,
   input logic [imh_pkg::NODE_ID_W-1:0]  rsp_out_node,
   input logic [imh_pkg::NEW_KEY_W-1:0]  rsp_out_key,
   input logic [imh_pkg::COUNT_W-1:0]    rsp_entry_count
);
   import imh_pkg::*;

   // a failed request reports no node and a zero key
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_out_node == '0 && rsp_out_key == '0)
      else $error("failed request reports a node");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready after transfer");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_count) && $stable(rsp_out_key))
      else $error("stalled response changed");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("active right after reset");

   // an empty-heap report only comes with a zero count
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == '0)
      else $error("empty status with entries");
endmodule

bind indexed_min_heap_core imh_checker u_imh_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_status(rsp.status),
   .rsp_out_node(rsp.out_node),
   .rsp_out_key(rsp.out_key),
   .rsp_entry_count(rsp.entry_count)
);

// ----- verif/indexed_min_heap_core_tb.sv -----
// Testbench for the indexed min-heap: random and directed requests checked against a local heap model.
`timescale 1ns / 1ps
module indexed_min_heap_core_tb;
   import imh_pkg::*;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [NODE_ID_W-1:0]  node_id;
      logic [NEW_KEY_W-1:0]  new_key;
   } heap_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [NODE_ID_W-1:0] out_node;
      logic [NEW_KEY_W-1:0] out_key;
      logic [COUNT_W-1:0]   entry_count;
   } heap_rsp_type;

   localparam int DEPTH = HEAP_DEPTH_DEF;
   localparam int IDS   = NODE_IDS_DEF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int FILL_IDS = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   imh_req_if req ();
   imh_rsp_if rsp ();

   indexed_min_heap_core u_dut (.clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source));

   // heap shadow
   logic [NEW_KEY_W-1:0] sh_keys [DEPTH];
   logic [NODE_ID_W-1:0] sh_nodes [DEPTH];
   int                   sh_pos [IDS];
   bit                   sh_present [IDS];
   int                   sh_fill = 0;

   heap_req_type pending_reqs [$];
   heap_rsp_type expected_rsps [$];
   int  error_count = 0;
   bit  calm_phase = 0;
   bit  hold_start = 0;
   bit  hold_done = 0;
   int  hold_rsp = 0;   // long receiver hold-off, in cycles
   int  src_gap = 0;
   int  sink_gap = 0;
   int  idle_cycles = 0;

   function automatic void heap_place(int slot, logic [NODE_ID_W-1:0] n,
                                      logic [NEW_KEY_W-1:0] k);
      sh_nodes[slot] = n;
      sh_keys[slot] = k;
      sh_pos[n] = slot;
   endfunction

   function automatic int heap_raise(int slot);
      logic [NODE_ID_W-1:0] n;
      logic [NEW_KEY_W-1:0] k;
      int parent;
      n = sh_nodes[slot];
      k = sh_keys[slot];
      while (slot > 0) begin
         parent = (slot - 1) >> 1;
         if (k >= sh_keys[parent]) break;
         heap_place(slot, sh_nodes[parent], sh_keys[parent]);
         slot = parent;
      end
      heap_place(slot, n, k);
      return slot;
   endfunction

   function automatic void heap_lower(int slot);
      logic [NODE_ID_W-1:0] n;
      logic [NEW_KEY_W-1:0] k;
      int left, right, pick;
      n = sh_nodes[slot];
      k = sh_keys[slot];
      forever begin
         left = 2 * slot + 1;
         right = left + 1;
         if (left >= sh_fill) break;
         if (right >= sh_fill || sh_keys[left] < sh_keys[right]) pick = left;
         else pick = right;
         if (sh_keys[pick] >= k) break;
         heap_place(slot, sh_nodes[pick], sh_keys[pick]);
         slot = pick;
      end
      heap_place(slot, n, k);
   endfunction

   function automatic heap_rsp_type heap_apply(heap_req_type r);
      heap_rsp_type o;
      int slot;
      o = '0;
      o.status = ST_OK;
      case (r.req_type)
         REQ_INSERT: begin
            if (sh_present[r.node_id]) o.status = ST_ABSENT;
            else if (sh_fill >= DEPTH) o.status = ST_FULL;
            else begin
               heap_place(sh_fill, r.node_id, r.new_key);
               sh_present[r.node_id] = 1;
               sh_fill++;
               void'(heap_raise(sh_fill - 1));
            end
         end
         REQ_POP: begin
            if (sh_fill == 0) o.status = ST_EMPTY;
            else begin
               o.out_node = sh_nodes[0];
               o.out_key = sh_keys[0];
               sh_present[sh_nodes[0]] = 0;
               sh_fill--;
               if (sh_fill > 0) begin
                  heap_place(0, sh_nodes[sh_fill], sh_keys[sh_fill]);
                  heap_lower(0);
               end
            end
         end
         REQ_CHANGE: begin
            if (!sh_present[r.node_id] || sh_pos[r.node_id] >= sh_fill) o.status = ST_ABSENT;
            else begin
               slot = sh_pos[r.node_id];
               sh_keys[slot] = r.new_key;
               if (heap_raise(slot) == slot) heap_lower(slot);
            end
         end
         default: ;
      endcase
      o.entry_count = sh_fill[COUNT_W-1:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic heap_req_type mk(req_code_type t, int n, int k);
      heap_req_type r;
      r.req_type = t;
      r.node_id = n[NODE_ID_W-1:0];
      r.new_key = k[NEW_KEY_W-1:0];
      return r;
   endfunction

   // keys: mostly small range for ties, sometimes full range
   function automatic int rand_key();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 15);
         1: return $urandom_range(0, 24'hFFFFFF);
         default: return $urandom_range(0, 2000);
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.req_type <= '0;
         req.node_id <= '0;
         req.new_key <= '0;
      end else begin
         if (req.valid && req.ready) expected_rsps.push_back(heap_apply(
            {req.req_type, req.node_id, req.new_key}));
         if (!req.valid || req.ready) begin
            if (src_gap > 0) begin
               src_gap <= src_gap - 1;
               req.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               {req.req_type, req.node_id, req.new_key} <= pending_reqs.pop_front();
               req.valid <= 1'b1;
               if (!calm_phase && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 13);
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_rsp > 0) begin
         hold_rsp <= hold_rsp - 1;
      end else if (hold_start && !hold_done) begin
         hold_rsp <= 400;
         hold_done <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      heap_rsp_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transfer", 1, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp.status !== want.status)
                  report_mismatch("status", rsp.status, want.status);
               if (rsp.out_node !== want.out_node)
                  report_mismatch("out_node", rsp.out_node, want.out_node);
               if (rsp.out_key !== want.out_key)
                  report_mismatch("out_key", rsp.out_key, want.out_key);
               if (rsp.entry_count !== want.entry_count)
                  report_mismatch("entry_count", rsp.entry_count, want.entry_count);
            end
         end
         if (hold_rsp > 0) begin
            rsp.ready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            if (!calm_phase && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 13);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles > WATCHDOG_LIMIT + IDS) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int live [$];
      int i, k, pick;

      // directed: empty pop, extremes, ties, absent and duplicate nodes, unused code
      pending_reqs.push_back(mk(REQ_POP, 0, 0));
      pending_reqs.push_back(mk(REQ_CHANGE, 5, 7));
      pending_reqs.push_back(mk(REQ_NONE, 1023, 24'hFFFFFF));
      pending_reqs.push_back(mk(REQ_INSERT, 1023, 24'hFFFFFF));
      pending_reqs.push_back(mk(REQ_INSERT, 0, 0));
      pending_reqs.push_back(mk(REQ_INSERT, 0, 9));
      pending_reqs.push_back(mk(REQ_INSERT, 512, 100));
      pending_reqs.push_back(mk(REQ_INSERT, 511, 100));
      pending_reqs.push_back(mk(REQ_INSERT, 7, 100));
      pending_reqs.push_back(mk(REQ_CHANGE, 1023, 0));
      pending_reqs.push_back(mk(REQ_CHANGE, 0, 24'hFFFFFF));
      pending_reqs.push_back(mk(REQ_CHANGE, 7, 100));
      pending_reqs.push_back(mk(REQ_CHANGE, 300, 1));
      for (i = 0; i < 7; i++) pending_reqs.push_back(mk(REQ_POP, 0, 0));

      // build a deep heap from shuffled ids, then duplicate insert, key changes, pops
      for (i = 0; i < IDS; i++) live.push_back(i);
      live.shuffle();
      for (i = 0; i < FILL_IDS; i++) pending_reqs.push_back(mk(REQ_INSERT, live[i], rand_key()));
      pending_reqs.push_back(mk(REQ_INSERT, live[0], 5));
      for (i = 0; i < 40; i++)
         pending_reqs.push_back(mk(REQ_CHANGE, live[$urandom_range(0, FILL_IDS - 1)],
                                   rand_key()));
      for (i = 0; i < 100; i++) pending_reqs.push_back(mk(REQ_POP, 0, 0));
      live.delete();

      // random mix on a small id pool to keep the heap shallow and lively
      for (i = 0; i < 290; i++) begin
         k = $urandom_range(0, 99);
         if (k < 40) begin
            pick = (k < 5) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
            pending_reqs.push_back(mk(REQ_INSERT, pick, rand_key()));
         end else if (k < 65) begin
            pending_reqs.push_back(mk(REQ_POP, $urandom_range(0, 1023), rand_key()));
         end else if (k < 97) begin
            pick = (k < 70) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
            pending_reqs.push_back(mk(REQ_CHANGE, pick, rand_key()));
         end else begin
            pending_reqs.push_back(mk(REQ_NONE, $urandom_range(0, 1023), rand_key()));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // receiver holds off so the input stalls behind the held response
      wait (pending_reqs.size() < 500);
      @(posedge clock);
      hold_start = 1'b1;

      wait (pending_reqs.size() < 120);
      calm_phase = 1;
      wait (pending_reqs.size() == 0 && !req.valid && expected_rsps.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
